@@ hw/rtl/drd_pkg.sv @@
`timescale 1ns / 1ps

package drd_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int FRAC_BITS_DEFAULT  = 16;

    // configuration register widths
    localparam int CLASS_BITS  = 8;
    localparam int THR_BITS    = 17;
    localparam int INV_BITS    = 25;
    localparam int PAD_BITS    = 12;
    localparam int IMG_BITS    = 14;
    localparam int CFG_DATA_BITS = 25;
    localparam int CFG_IDX_BITS  = 3;

    localparam logic [CLASS_BITS-1:0] CLASS_COUNT_RESET = 8'd80;
    localparam logic [THR_BITS-1:0]   THR_RESET         = 17'd32768;
    localparam logic [INV_BITS-1:0]   INV_RESET         = 25'd65536;
    localparam logic [IMG_BITS-1:0]   IMG_RESET         = 14'd640;

    // row layout
    localparam int POS_BITS = 9;
    localparam logic [POS_BITS-1:0] POS_MAX         = 9'd511;
    localparam logic [POS_BITS-1:0] BOX_ELEMENTS    = 9'd4;
    localparam logic [POS_BITS-1:0] SCORE_START_OBJ = 9'd5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_HAS_OBJ      = 3'd0,
        REG_CLASS_COUNT  = 3'd1,
        REG_CONF_THR     = 3'd2,
        REG_INV_SCALE    = 3'd3,
        REG_PAD_LEFT     = 3'd4,
        REG_PAD_TOP      = 3'd5,
        REG_IMAGE_WIDTH  = 3'd6,
        REG_IMAGE_HEIGHT = 3'd7
    } t_cfg_index;

endpackage

@@ hw/rtl/detector_row_decode.sv @@
`timescale 1ns / 1ps
// throughput: one element per cycle while o_s_tready is high, which output
// stalls can hold low; results leave through a 5 stage pipeline
// (argmax capture, edge subtract and objectness multiply, box multiplies,
// shift and saturate, clip) whose empty stages collapse under output stalls
// reset: synchronous active-low i_rst_n clears row state, pipeline valids and
// restores the configuration register defaults

module detector_row_decode
    import drd_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT,
    parameter int FRAC_BITS  = FRAC_BITS_DEFAULT,
    localparam int IN_DATA_BITS  = ((VALUE_BITS + 7) / 8) * 8,
    localparam int OUT_FIELD_BITS = CLASS_BITS + 5 * VALUE_BITS - 2,
    localparam int OUT_DATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,

    input  logic                     i_s_tvalid,
    output logic                     o_s_tready,
    input  logic [IN_DATA_BITS-1:0]  i_s_tdata,    // element_value
    input  logic                     i_s_tlast,    // row_end

    output logic                     o_m_tvalid,
    input  logic                     i_m_tready,
    // class_index, confidence, box_left, box_top, box_width, box_height
    output logic [OUT_DATA_BITS-1:0] o_m_tdata,
    output logic                     o_m_tuser,    // class_valid

    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int V  = VALUE_BITS;
    localparam int F  = FRAC_BITS;
    localparam int EW = ((V > F + 13) ? V : F + 13) + 2;
    localparam int PX = EW + INV_BITS + 1;
    localparam int PW = V + INV_BITS + 1;
    localparam int WW = (2 * V > PX) ? 2 * V : PX;

    localparam logic signed [WW-1:0] SAT_HI = {{(WW-V+1){1'b0}}, {(V-1){1'b1}}};
    localparam logic signed [WW-1:0] SAT_LO = {{(WW-V+1){1'b1}}, {(V-1){1'b0}}};

    function automatic logic signed [V-1:0] sat_v(input logic signed [WW-1:0] a);
        logic signed [V-1:0] r;
        if (a > SAT_HI) begin
            r = SAT_HI[V-1:0];
        end else if (a < SAT_LO) begin
            r = SAT_LO[V-1:0];
        end else begin
            r = a[V-1:0];
        end
        return r;
    endfunction

    // configuration
    logic                  r_has_obj;
    logic [CLASS_BITS-1:0] r_class_count;
    logic [THR_BITS-1:0]   r_thr;
    logic [INV_BITS-1:0]   r_inv;
    logic [PAD_BITS-1:0]   r_pad_left;
    logic [PAD_BITS-1:0]   r_pad_top;
    logic [IMG_BITS-1:0]   r_img_w;
    logic [IMG_BITS-1:0]   r_img_h;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_obj     <= 1'b0;
            r_class_count <= CLASS_COUNT_RESET;
            r_thr         <= THR_RESET;
            r_inv         <= INV_RESET;
            r_pad_left    <= '0;
            r_pad_top     <= '0;
            r_img_w       <= IMG_RESET;
            r_img_h       <= IMG_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                REG_HAS_OBJ:      r_has_obj     <= i_cfg_data[0];
                REG_CLASS_COUNT:  r_class_count <= i_cfg_data[CLASS_BITS-1:0];
                REG_CONF_THR:     r_thr         <= i_cfg_data[THR_BITS-1:0];
                REG_INV_SCALE:    r_inv         <= i_cfg_data[INV_BITS-1:0];
                REG_PAD_LEFT:     r_pad_left    <= i_cfg_data[PAD_BITS-1:0];
                REG_PAD_TOP:      r_pad_top     <= i_cfg_data[PAD_BITS-1:0];
                REG_IMAGE_WIDTH:  r_img_w       <= i_cfg_data[IMG_BITS-1:0];
                REG_IMAGE_HEIGHT: r_img_h       <= i_cfg_data[IMG_BITS-1:0];
            endcase
        end
    end

    // pipeline valids and advance chain
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic go1, go2, go3, go4, go5;
    logic s_acc;

    assign go5 = !r_v5 || i_m_tready;
    assign go4 = !r_v4 || go5;
    assign go3 = !r_v3 || go4;
    assign go2 = !r_v2 || go3;
    assign go1 = !r_v1 || go2;

    assign o_s_tready = go1;
    assign s_acc      = i_s_tvalid && go1;

    // row accumulation
    logic [POS_BITS-1:0]      r_pos;
    logic signed [V-1:0]      r_box [4];
    logic signed [V-1:0]      r_obj;
    logic signed [V-1:0]      r_best;
    logic [CLASS_BITS-1:0]    r_cls;
    logic                     r_found;

    logic signed [V-1:0]      n_box [4];
    logic signed [V-1:0]      n_obj;
    logic signed [V-1:0]      n_best;
    logic [CLASS_BITS-1:0]    n_cls;
    logic                     n_found;
    logic signed [V-1:0]      in_val;
    logic [POS_BITS-1:0]      score_start;
    logic [POS_BITS-1:0]      score_off;
    logic                     in_scores;

    assign in_val      = signed'(i_s_tdata[V-1:0]);
    assign score_start = r_has_obj ? SCORE_START_OBJ : BOX_ELEMENTS;
    assign score_off   = r_pos - score_start;
    assign in_scores   = (r_pos >= score_start)
                      && (score_off < {1'b0, r_class_count});

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            n_box[k] = (r_pos == POS_BITS'(k)) ? in_val : r_box[k];
        end
        n_obj   = (r_has_obj && r_pos == BOX_ELEMENTS) ? in_val : r_obj;
        n_best  = r_best;
        n_cls   = r_cls;
        n_found = r_found;
        if (r_pos >= BOX_ELEMENTS && in_scores && in_val > r_best) begin
            n_best  = in_val;
            n_cls   = score_off[CLASS_BITS-1:0];
            n_found = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (s_acc && i_s_tlast)) begin
            r_pos   <= '0;
            r_obj   <= '0;
            r_best  <= '0;
            r_cls   <= '0;
            r_found <= 1'b0;
            for (int k = 0; k < 4; k++) begin
                r_box[k] <= '0;
            end
        end else if (s_acc) begin
            if (r_pos != POS_MAX) begin
                r_pos <= r_pos + POS_BITS'(1);
            end
            r_obj   <= n_obj;
            r_best  <= n_best;
            r_cls   <= n_cls;
            r_found <= n_found;
            for (int k = 0; k < 4; k++) begin
                r_box[k] <= n_box[k];
            end
        end
    end

    // stage payloads
    logic signed [V-1:0]    r_s1_cx, r_s1_cy, r_s1_w, r_s1_h, r_s1_obj, r_s1_best;
    logic [CLASS_BITS-1:0]  r_s1_cls, r_s2_cls, r_s3_cls, r_s4_cls, r_s5_cls;
    logic                   r_s1_found, r_s2_found, r_s3_found, r_s4_found, r_s5_found;

    logic signed [EW-1:0]   r_s2_ex, r_s2_ey;
    logic signed [V-1:0]    r_s2_w, r_s2_h, r_s2_best;
    logic signed [2*V-1:0]  r_s2_prod;

    logic signed [PX-1:0]   r_s3_px, r_s3_py;
    logic signed [PW-1:0]   r_s3_pw, r_s3_ph;
    logic signed [V-1:0]    r_s3_conf;

    logic [V-2:0]           r_s4_x, r_s4_y;
    logic signed [V-1:0]    r_s4_w, r_s4_h, r_s4_conf;

    logic [V-2:0]           r_s5_x, r_s5_y;
    logic signed [V-1:0]    r_s5_w, r_s5_h, r_s5_conf;

    logic signed [EW-1:0]   ex_pad, ey_pad, n_ex, n_ey;
    logic signed [INV_BITS:0] inv_s;
    logic signed [V-1:0]    n_conf, n_x, n_y, n_ws, n_hs, room_x, room_y;
    logic                   keep;

    always_comb begin
        ex_pad = signed'(EW'({r_pad_left, {F{1'b0}}}));
        ey_pad = signed'(EW'({r_pad_top, {F{1'b0}}}));
        n_ex   = EW'(r_s1_cx) - ex_pad - EW'(r_s1_w >>> 1);
        n_ey   = EW'(r_s1_cy) - ey_pad - EW'(r_s1_h >>> 1);
        inv_s  = signed'({1'b0, r_inv});

        n_conf = r_has_obj ? sat_v(WW'(r_s2_prod) >>> F) : r_s2_best;
        keep   = WW'(r_s3_conf) >= signed'(WW'({1'b0, r_thr}));

        // edges rise to zero when negative
        n_x  = sat_v(WW'(r_s3_px) >>> F);
        n_y  = sat_v(WW'(r_s3_py) >>> F);
        if (n_x < 0) begin
            n_x = '0;
        end
        if (n_y < 0) begin
            n_y = '0;
        end
        n_ws = sat_v(WW'(r_s3_pw) >>> F);
        n_hs = sat_v(WW'(r_s3_ph) >>> F);

        room_x = sat_v(signed'(WW'({1'b0, r_img_w, {F{1'b0}}}))
                       - signed'(WW'({1'b0, r_s4_x})));
        room_y = sat_v(signed'(WW'({1'b0, r_img_h, {F{1'b0}}}))
                       - signed'(WW'({1'b0, r_s4_y})));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (go1) r_v1 <= s_acc && i_s_tlast;
            if (go2) r_v2 <= r_v1;
            if (go3) r_v3 <= r_v2;
            // rows below threshold drop out here
            if (go4) r_v4 <= r_v3 && keep;
            if (go5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go1) begin
            r_s1_cx    <= n_box[0];
            r_s1_cy    <= n_box[1];
            r_s1_w     <= n_box[2];
            r_s1_h     <= n_box[3];
            r_s1_obj   <= n_obj;
            r_s1_best  <= n_best;
            r_s1_cls   <= n_cls;
            r_s1_found <= n_found;
        end
        if (go2) begin
            r_s2_ex    <= n_ex;
            r_s2_ey    <= n_ey;
            r_s2_w     <= r_s1_w;
            r_s2_h     <= r_s1_h;
            r_s2_best  <= r_s1_best;
            r_s2_prod  <= r_s1_obj * r_s1_best;
            r_s2_cls   <= r_s1_cls;
            r_s2_found <= r_s1_found;
        end
        if (go3) begin
            r_s3_px    <= r_s2_ex * inv_s;
            r_s3_py    <= r_s2_ey * inv_s;
            r_s3_pw    <= r_s2_w * inv_s;
            r_s3_ph    <= r_s2_h * inv_s;
            r_s3_conf  <= n_conf;
            r_s3_cls   <= r_s2_cls;
            r_s3_found <= r_s2_found;
        end
        if (go4) begin
            r_s4_x     <= n_x[V-2:0];
            r_s4_y     <= n_y[V-2:0];
            r_s4_w     <= n_ws;
            r_s4_h     <= n_hs;
            r_s4_conf  <= r_s3_conf;
            r_s4_cls   <= r_s3_cls;
            r_s4_found <= r_s3_found;
        end
        if (go5) begin
            r_s5_x     <= r_s4_x;
            r_s5_y     <= r_s4_y;
            r_s5_w     <= (r_s4_w < room_x) ? r_s4_w : room_x;
            r_s5_h     <= (r_s4_h < room_y) ? r_s4_h : room_y;
            r_s5_conf  <= r_s4_conf;
            r_s5_cls   <= r_s4_cls;
            r_s5_found <= r_s4_found;
        end
    end

    assign o_m_tvalid = r_v5;
    assign o_m_tuser  = r_s5_found;
    assign o_m_tdata  = OUT_DATA_BITS'({r_s5_h, r_s5_w, r_s5_y, r_s5_x,
                                        r_s5_conf, r_s5_cls});

    // row state is clear after a row's last element
    a_row_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && i_s_tlast) |=> (r_pos == '0 && !r_found && r_best == '0))
        else $error("row state not cleared after last element");

    // position counts accepted elements and holds at its maximum
    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_acc && !i_s_tlast && r_pos != POS_MAX)
            |=> (r_pos == $past(r_pos) + POS_BITS'(1)))
        else $error("element position did not advance");

    // with no class above zero the confidence and class index must be zero
    a_no_class_conf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (r_s5_conf == '0 && r_s5_cls == '0))
        else $error("nonzero confidence or class without a valid class");

    // a stalled result is never overwritten by an earlier stage
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(r_s5_conf)
                                         && $stable(r_s5_x) && $stable(r_s5_w)))
        else $error("pending result changed under stall");

endmodule
